FILE: rtl/mefr_pkg.sv
// Package with types and constants of the manchester edge frame receiver
package mefr_pkg;

  // frame geometry, fixed by the widths of the item fields
  localparam int FRAME_BITS  = 32;
  localparam int TIME_WIDTH  = 32;
  localparam int COUNT_WIDTH = $clog2(FRAME_BITS + 1);
  localparam int THR_WIDTH   = 16;

  localparam logic [THR_WIDTH-1:0] THRESHOLD_RESET = 16'd750;

  // request opcodes
  localparam logic OP_ARM  = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  // frame kinds
  localparam logic [1:0] KIND_PLAIN  = 2'd0;
  localparam logic [1:0] KIND_GW_REQ = 2'd1;
  localparam logic [1:0] KIND_GW_RSP = 2'd2;

  // line channels
  localparam logic CH_PRIMARY   = 1'b0;
  localparam logic CH_SECONDARY = 1'b1;

  // configuration register indexes
  localparam logic CFG_GATEWAY_ENABLE = 1'b0;
  localparam logic CFG_BIT_THRESHOLD  = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_WAIT    = 3'd1,
    PH_START   = 3'd2,
    PH_RECV    = 3'd3,
    PH_READY   = 3'd4,
    PH_INVALID = 3'd5
  } phase_t;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  arm_kind;
    logic        edge_channel;
    logic        edge_level;
    logic [31:0] edge_time_us;
  } in_item_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  frame_kind;
    logic [31:0] frame_word;
    logic [5:0]  bit_count;
    logic        frame_done;
  } out_item_t;

  typedef struct packed {
    phase_t                   phase;
    logic [1:0]               kind;
    logic [TIME_WIDTH-1:0]    last_time;
    logic [COUNT_WIDTH-1:0]   bits;
    logic [FRAME_BITS-1:0]    word;
  } rx_state_t;

  typedef struct packed {
    logic                 gateway_enable;
    logic [THR_WIDTH-1:0] bit_threshold_us;
  } rx_cfg_t;

endpackage

FILE: rtl/mefr_step.sv
// Next-state and result logic for one request of the frame receiver
module mefr_step import mefr_pkg::*; (
  input  rx_state_t st,
  input  rx_cfg_t   cfg,
  input  in_item_t  item,
  output rx_state_t st_next,
  output out_item_t res
);

  logic [TIME_WIDTH-1:0] elapsed;
  logic [TIME_WIDTH-1:0] thr;
  logic                  in_frame;
  logic                  take;
  logic                  done;

  // spacing since the last sampled edge, wrapping
  assign elapsed = TIME_WIDTH'(item.edge_time_us) - st.last_time;
  assign thr     = TIME_WIDTH'(cfg.bit_threshold_us);

  // edge filter by phase, kind and channel
  assign in_frame = (st.phase == PH_WAIT) || (st.phase == PH_START) ||
                    (st.phase == PH_RECV);
  always_comb begin
    case (st.kind)
      KIND_PLAIN:  take = 1'b1;
      KIND_GW_REQ: take = cfg.gateway_enable && (item.edge_channel == CH_PRIMARY);
      default:     take = cfg.gateway_enable && (item.edge_channel == CH_SECONDARY);
    endcase
    take = take && in_frame;
  end

  // state update
  always_comb begin
    st_next = st;
    done    = 1'b0;
    if (item.opcode == OP_ARM) begin
      if (item.arm_kind == KIND_PLAIN || item.arm_kind == KIND_GW_REQ ||
          item.arm_kind == KIND_GW_RSP) begin
        st_next.kind      = item.arm_kind;
        st_next.phase     = PH_WAIT;
        st_next.word      = '0;
        st_next.bits      = '0;
        st_next.last_time = '0;
      end
    end else if (take) begin
      if (st.phase == PH_WAIT) begin
        st_next.phase     = item.edge_level ? PH_START : PH_INVALID;
        st_next.last_time = TIME_WIDTH'(item.edge_time_us);
      end else if (st.phase == PH_START) begin
        if (elapsed < thr && !item.edge_level) begin
          st_next.phase     = PH_RECV;
          st_next.last_time = TIME_WIDTH'(item.edge_time_us);
          st_next.bits      = '0;
          st_next.word      = '0;
        end else if (elapsed >= thr) begin
          st_next.phase     = PH_INVALID;
          st_next.last_time = TIME_WIDTH'(item.edge_time_us);
        end
      end else if (elapsed > thr) begin
        if (st.bits < COUNT_WIDTH'(FRAME_BITS)) begin
          st_next.word      = {st.word[FRAME_BITS-2:0], ~item.edge_level};
          st_next.last_time = TIME_WIDTH'(item.edge_time_us);
          st_next.bits      = st.bits + COUNT_WIDTH'(1);
        end else begin
          st_next.phase     = PH_READY;
          st_next.last_time = TIME_WIDTH'(item.edge_time_us);
          done              = 1'b1;
        end
      end
    end
  end

  // result shows the state after the request
  always_comb begin
    res.phase      = st_next.phase;
    res.frame_kind = st_next.kind;
    res.frame_word = 32'(st_next.word);
    res.bit_count  = 6'(st_next.bits);
    res.frame_done = done;
  end

endmodule

FILE: rtl/manchester_edge_frame_receiver_core.sv
// Top level of the manchester edge frame receiver core
// Takes one request (arm or timestamped line edge) per clock while the result side is not
// stalled, and returns one result per request, showing phase, kind, word and bit count
// after that request. A request is held in the input register, then the combinational state
// update writes the result register; a stalled result holds both registers. The sustained
// rate is one request per cycle while out_ready stays high, and the logic path between the
// registers is the subtract, compare and shift of the state update.
// Configuration writes are always ready and take effect at once; write them only while
// no request is in flight.
module manchester_edge_frame_receiver_core import mefr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [THR_WIDTH-1:0] cfg_data
);

  rx_cfg_t   cfg;
  rx_state_t st;
  rx_state_t st_next;
  in_item_t  s1_item;
  logic      s1_valid;
  logic      s1_fire;
  logic      out_free;
  out_item_t res;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gateway_enable   <= 1'b0;
      cfg.bit_threshold_us <= THRESHOLD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GATEWAY_ENABLE: cfg.gateway_enable   <= cfg_data[0];
        CFG_BIT_THRESHOLD:  cfg.bit_threshold_us <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake between stages
  assign out_free = !out_valid || out_ready;
  assign s1_fire  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  // state update
  mefr_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (s1_item),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase     <= PH_IDLE;
      st.kind      <= KIND_PLAIN;
      st.last_time <= '0;
      st.bits      <= '0;
      st.word      <= '0;
    end else if (s1_fire) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= res;
    end
  end

`ifndef SYNTH
  // a completed frame is always in the ready phase with all bits taken
  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |->
      out_data.phase == PH_READY && out_data.bit_count == 6'(FRAME_BITS))
    else $error("frame_done without a full frame in ready phase");

  // bit count never passes the frame length
  a_bits_bound: assert property (@(posedge clk) disable iff (rst)
    st.bits <= COUNT_WIDTH'(FRAME_BITS))
    else $error("bit count beyond frame length");

  // input stalls only when a request waits behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled without cause");

  // a stalled result is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
`endif

endmodule

FILE: tb/testbench.sv
// Testbench of the manchester edge frame receiver core: directed and random requests, self-checked
`timescale 1ns / 1ps

module testbench;
  import mefr_pkg::*;

  // arm kind that the receiver must ignore
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_index = CFG_GATEWAY_ENABLE;
  logic [THR_WIDTH-1:0] cfg_data = '0;

  manchester_edge_frame_receiver_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // decoder shadow state and configuration
  phase_t         dec_phase = PH_IDLE;
  logic [1:0]     dec_kind = KIND_PLAIN;
  logic [31:0]    dec_last = '0;
  logic [5:0]     dec_bits = '0;
  logic [31:0]    dec_word = '0;
  logic           gw_on = 1'b0;
  logic [15:0]    thr_us = THRESHOLD_RESET;

  in_item_t  req_queue[$];
  out_item_t expected_results[$];
  int        error_count = 0;
  int        accepted_count = 0;
  int        queued_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic      in_took = 1'b0;
  int        hold_at = 32'h7fff_ffff;
  int        hold_left = 0;
  logic      hold_done = 1'b0;
  logic [31:0] gen_last = '0;

  // next decoder state and result for one request
  function automatic out_item_t decode_step(in_item_t req);
    logic [31:0] span;
    logic        takes;
    logic        done;
    out_item_t   res;
    done = 1'b0;
    span = req.edge_time_us - dec_last;
    if (req.opcode == OP_ARM) begin
      if (req.arm_kind != KIND_UNKNOWN) begin
        dec_kind = req.arm_kind;
        dec_phase = PH_WAIT;
        dec_word = '0;
        dec_bits = '0;
        dec_last = '0;
      end
    end else begin
      takes = (dec_phase == PH_WAIT || dec_phase == PH_START || dec_phase == PH_RECV);
      if (dec_kind != KIND_PLAIN) begin
        if (dec_kind == KIND_GW_REQ)
          takes = takes && gw_on && (req.edge_channel == CH_PRIMARY);
        else
          takes = takes && gw_on && (req.edge_channel == CH_SECONDARY);
      end
      if (takes) begin
        if (dec_phase == PH_WAIT) begin
          dec_phase = req.edge_level ? PH_START : PH_INVALID;
          dec_last = req.edge_time_us;
        end else if (dec_phase == PH_START) begin
          if (span < {16'd0, thr_us} && !req.edge_level) begin
            dec_phase = PH_RECV;
            dec_last = req.edge_time_us;
            dec_bits = '0;
            dec_word = '0;
          end else if (span >= {16'd0, thr_us}) begin
            dec_phase = PH_INVALID;
            dec_last = req.edge_time_us;
          end
        end else if (span > {16'd0, thr_us}) begin
          // data bit or stop bit
          if (dec_bits < FRAME_BITS) begin
            dec_word = {dec_word[30:0], ~req.edge_level};
            dec_bits = dec_bits + 6'd1;
            dec_last = req.edge_time_us;
          end else begin
            dec_phase = PH_READY;
            dec_last = req.edge_time_us;
            done = 1'b1;
          end
        end
      end
    end
    res.phase = dec_phase;
    res.frame_kind = dec_kind;
    res.frame_word = dec_word;
    res.bit_count = dec_bits;
    res.frame_done = done;
    return res;
  endfunction

  task automatic check_result(out_item_t got, out_item_t want);
    if (got.phase !== want.phase) begin
      $error("phase expected %0d got %0d", want.phase, got.phase);
      error_count++;
    end
    if (got.frame_kind !== want.frame_kind) begin
      $error("frame_kind expected %0d got %0d", want.frame_kind, got.frame_kind);
      error_count++;
    end
    if (got.frame_word !== want.frame_word) begin
      $error("frame_word expected %h got %h", want.frame_word, got.frame_word);
      error_count++;
    end
    if (got.bit_count !== want.bit_count) begin
      $error("bit_count expected %0d got %0d", want.bit_count, got.bit_count);
      error_count++;
    end
    if (got.frame_done !== want.frame_done) begin
      $error("frame_done expected %0d got %0d", want.frame_done, got.frame_done);
      error_count++;
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= req_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_count >= hold_at) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // accepted requests feed the decoder, results are checked in order
  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        expected_results.push_back(decode_step(in_data));
        accepted_count++;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          check_result(out_data, expected_results.pop_front());
        end
      end
    end
  end

  function automatic in_item_t arm_req(logic [1:0] k);
    logic [63:0] raw;
    in_item_t    r;
    raw = {$urandom, $urandom};
    r = raw[$bits(in_item_t)-1:0];
    r.opcode = OP_ARM;
    r.arm_kind = k;
    return r;
  endfunction

  function automatic in_item_t edge_req(logic ch, logic lvl, logic [31:0] t);
    logic [63:0] raw;
    in_item_t    r;
    raw = {$urandom, $urandom};
    r = raw[$bits(in_item_t)-1:0];
    r.opcode = OP_EDGE;
    r.edge_channel = ch;
    r.edge_level = lvl;
    r.edge_time_us = t;
    return r;
  endfunction

  // spacing beyond the threshold, often right at the boundary
  function automatic logic [31:0] long_gap(int unsigned thr);
    case ($urandom_range(3))
      0: return thr + 1;
      1: return thr + 1 + $urandom_range(20);
      default: return thr + 1 + $urandom_range(thr);
    endcase
  endfunction

  // spacing at or inside the threshold
  function automatic logic [31:0] short_gap(int unsigned thr);
    if ($urandom_range(1) == 0)
      return thr;
    return $urandom_range(thr);
  endfunction

  task automatic put(in_item_t r);
    req_queue.push_back(r);
    queued_count++;
  endtask

  // one frame, mostly well formed, sometimes broken on purpose
  task automatic queue_frame(logic [1:0] k, int unsigned thr);
    logic        ch;
    logic [31:0] t;
    int unsigned flaw;
    int unsigned cut_at;
    flaw = $urandom_range(99);
    cut_at = $urandom_range(FRAME_BITS - 1);
    if (k == KIND_GW_REQ)
      ch = CH_PRIMARY;
    else if (k == KIND_GW_RSP)
      ch = CH_SECONDARY;
    else
      ch = 1'($urandom);
    put(arm_req(k));
    t = $urandom;
    // low first edge
    if (flaw < 4) begin
      put(edge_req(ch, 1'b0, t));
      return;
    end
    put(edge_req(ch, 1'b1, t));
    if (thr > 1 && $urandom_range(2) == 0)
      put(edge_req(ch, 1'b1, t + $urandom_range(thr - 1)));
    // start bit confirmed too late
    if (flaw < 8) begin
      put(edge_req(ch, 1'($urandom), t + thr + $urandom_range(3)));
      return;
    end
    t = t + ((thr == 0) ? 0 : $urandom_range(thr - 1));
    put(edge_req(ch, 1'b0, t));
    for (int b = 0; b < FRAME_BITS; b++) begin
      // re-arm in the middle of the frame
      if (flaw < 12 && b == cut_at) begin
        put(arm_req(2'($urandom)));
        return;
      end
      if (flaw < 16 && b == cut_at)
        put(arm_req(KIND_UNKNOWN));
      // edge on the other line of a gateway frame
      if (k != KIND_PLAIN && $urandom_range(7) == 0)
        put(edge_req(~ch, 1'($urandom), t + long_gap(thr)));
      if ($urandom_range(2) == 0)
        put(edge_req(ch, 1'($urandom), t + short_gap(thr)));
      t = t + long_gap(thr);
      put(edge_req(ch, 1'($urandom), t));
    end
    // stop bit, then maybe a stray edge after completion
    t = t + long_gap(thr);
    put(edge_req(ch, 1'($urandom), t));
    if ($urandom_range(3) == 0)
      put(edge_req(ch, 1'($urandom), t + long_gap(thr)));
    gen_last = t;
  endtask

  task automatic fill_frames(int unsigned n);
    int unsigned goal;
    int unsigned pick;
    logic [63:0] raw;
    goal = queued_count + n;
    while (queued_count < goal) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        raw = {$urandom, $urandom};
        req_queue.push_back(raw[$bits(in_item_t)-1:0]);
      end else if (pick < 6) begin
        queue_frame(KIND_PLAIN, 32'(thr_us));
      end else if (pick < 8) begin
        queue_frame(KIND_GW_REQ, 32'(thr_us));
      end else begin
        queue_frame(KIND_GW_RSP, 32'(thr_us));
      end
    end
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_GATEWAY_ENABLE)
      gw_on = val[0];
    else
      thr_us = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_mode(logic gw, logic [15:0] thr, int unsigned s_pct, int unsigned r_pct);
    logic [15:0] v;
    v = 16'($urandom);
    v[0] = gw;
    write_reg(CFG_GATEWAY_ENABLE, v);
    write_reg(CFG_BIT_THRESHOLD, thr);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
  endtask

  // wait until every request has been answered
  task automatic drain;
    while (req_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed requests at reset configuration
    send_idle_pct = 20;
    recv_idle_pct = 86;
    put(arm_req(KIND_UNKNOWN));
    put(edge_req(CH_PRIMARY, 1'b1, 32'h0000_0000));
    put(arm_req(KIND_GW_REQ));
    put(edge_req(CH_PRIMARY, 1'b1, 32'hFFFF_FFFF));
    put(arm_req(KIND_PLAIN));
    put(edge_req(CH_SECONDARY, 1'b0, 32'd100));
    put(edge_req(CH_PRIMARY, 1'b1, 32'd5000));
    put(arm_req(KIND_PLAIN));
    put(edge_req(CH_PRIMARY, 1'b1, 32'hFFFF_FFFF));
    put(edge_req(CH_PRIMARY, 1'b1, 32'd9));
    put(edge_req(CH_SECONDARY, 1'b0, 32'd748));
    put(edge_req(CH_PRIMARY, 1'b0, 32'd1498));
    put(edge_req(CH_PRIMARY, 1'b0, 32'd1499));
    put(edge_req(CH_SECONDARY, 1'b1, 32'd2250));
    put(arm_req(KIND_PLAIN));
    put(edge_req(CH_PRIMARY, 1'b1, 32'd0));
    put(edge_req(CH_PRIMARY, 1'b0, 32'd750));
    put(arm_req(KIND_GW_RSP));
    put(edge_req(CH_SECONDARY, 1'b1, 32'd40));
    put(arm_req(KIND_PLAIN));
    put(edge_req(CH_PRIMARY, 1'b1, 32'd1000));
    put(edge_req(CH_PRIMARY, 1'b1, 32'd1750));
    drain();

    // sender idles lightly, receiver heavily
    set_mode(1'b1, 16'd750, 20, 86);
    fill_frames(240);
    drain();
    set_mode(1'b0, 16'd1, 20, 86);
    fill_frames(240);
    drain();

    // the other way round
    set_mode(1'b1, 16'hFFFF, 86, 20);
    fill_frames(240);
    drain();
    set_mode(1'b1, 16'($urandom_range(3000, 2)), 86, 20);
    fill_frames(240);
    // leave a plain frame open in the receiving phase
    gen_last = $urandom;
    put(arm_req(KIND_PLAIN));
    put(edge_req(1'($urandom), 1'b1, gen_last));
    gen_last = gen_last + 1;
    put(edge_req(1'($urandom), 1'b0, gen_last));
    drain();

    // no idling, zero threshold, long receiver hold-off
    set_mode(1'b0, 16'd0, 0, 0);
    hold_at = accepted_count + 30;
    for (int i = 0; i < 48; i++) begin
      if ($urandom_range(3) != 0)
        gen_last = gen_last + $urandom_range(5, 1);
      put(edge_req(1'($urandom), 1'($urandom), gen_last));
    end
    fill_frames(220);
    drain();
    set_mode(1'b1, 16'd750, 0, 0);
    fill_frames(240);
    drain();

    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  // run time limit
  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

FILE: sim.f
rtl/mefr_pkg.sv
rtl/mefr_step.sv
rtl/manchester_edge_frame_receiver_core.sv
tb/testbench.sv
